@@ rtl/tdf_pkg.sv @@
package tdf_pkg;

    // Shared multiplier: 64-bit by 32-bit, built from two 32x32 partial products
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Shared divide / square-root unit
    localparam int DSQ_ARG_W   = 100;
    localparam int DSQ_RES_W   = 72;
    localparam int DSQ_REM_W   = 54;
    localparam int DSQ_DEN_W   = 32;
    localparam int DSQ_CNT_W   = 7;
    localparam int DIV_STEPS   = 72;
    localparam int SQRT_STEPS  = 50;
    localparam int ROOT_W      = 50;

    // Saturation bound of the wide intermediates
    localparam logic [63:0] WIDE_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

    // Smallest linear zone factor, 1.0 in Q8.8
    localparam logic [15:0] N_ONE = 16'd256;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_ACCEL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_PERIOD_H    = 2'd1;
    localparam logic [1:0] CFG_FILTER_N    = 2'd2;
    localparam logic [1:0] CFG_MAX_VEL     = 2'd3;

    typedef enum logic
    {
        DSQ_DIV  = 1'b0,
        DSQ_SQRT = 1'b1
    } dsq_mode_t;

    typedef struct packed
    {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
    } mul_req_t;

    typedef struct packed
    {
        logic                 start;
        dsq_mode_t            mode;
        logic [DSQ_ARG_W-1:0] arg;
        logic [DSQ_DEN_W-1:0] den;
    } dsq_req_t;

endpackage

@@ rtl/tracking_differentiator_fhan_core.sv @@
// Tracking differentiator with the time-optimal fhan law, Q16.16 state.
// Input channel (in_valid/in_ready): req_type 0 moves the tracker one sample
// toward value_in, req_type 1 loads value_in as position and clears velocity.
// Every input word yields one output word (out_valid/out_ready) carrying the
// smoothed position. Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data)
// is always ready and writes r, h, n or the velocity clamp; write it while
// no word is in flight.
// A load word passes through ST_OUT and enters the output register once that
// register is free. An update word takes eight or nine passes of the shared
// two-pass multiplier plus up to two runs of the shared divide / square-root
// unit, which retires one bit per cycle. One word is in flight at a time;
// the next is accepted the cycle after the result is registered. After reset
// the registers hold r = 100.0, h = about 1 ms, n = 1.0, no velocity clamp,
// and position and velocity are zero. A finished result waits in the output
// register while the next word is accepted; if the receiver still stalls
// when that word finishes, the block holds until it is taken.
module tracking_differentiator_fhan_core
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic signed [31:0] value_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] position_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tdf_pkg::*;

    localparam logic signed [63:0] DATA_MAX_W = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] DATA_MIN_W = -DATA_MAX_W - 64'sd1;

    typedef enum logic [21:0]
    {
        ST_IDLE = 22'h000001,
        ST_H0   = 22'h000002,
        ST_D    = 22'h000004,
        ST_D0   = 22'h000008,
        ST_VH   = 22'h000010,
        ST_YABS = 22'h000020,
        ST_ARGA = 22'h000040,
        ST_ARGB = 22'h000080,
        ST_BR   = 22'h000100,
        ST_LDIV = 22'h000200,
        ST_SQRT = 22'h000400,
        ST_SUM  = 22'h000800,
        ST_ACCA = 22'h001000,
        ST_ACCB = 22'h002000,
        ST_ACCM = 22'h004000,
        ST_ACCD = 22'h008000,
        ST_AH   = 22'h010000,
        ST_VCLP = 22'h020000,
        ST_VSAT = 22'h040000,
        ST_PVH  = 22'h080000,
        ST_PSAT = 22'h100000,
        ST_OUT  = 22'h200000
    } seq_state_t;

    function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [63:0] v);
        logic signed [63:0] c;
        begin
            c = (v > DATA_MAX_W) ? DATA_MAX_W : ((v < DATA_MIN_W) ? DATA_MIN_W : v);
            return c[DATA_WIDTH-1:0];
        end
    endfunction

    seq_state_t state_reg, state_next;
    logic       go_reg, go_next;
    logic       out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic [31:0] r_reg, r_next;
    logic [31:0] h_reg, h_next;
    logic [15:0] n_reg, n_next;
    logic [30:0] vmax_reg, vmax_next;

    logic signed [DATA_WIDTH-1:0] pos_reg, pos_next;
    logic signed [DATA_WIDTH-1:0] vel_reg, vel_next;

    logic signed [31:0] tgt_reg, tgt_next;
    logic signed [63:0] err_reg, err_next;
    logic [39:0]        h0_reg, h0_next;
    logic [31:0]        d_reg, d_next;
    logic [39:0]        d0_reg, d0_next;
    logic signed [63:0] y_reg, y_next;
    logic [63:0]        ay_reg, ay_next;
    logic [DSQ_ARG_W-1:0] arg_reg, arg_next;
    logic signed [63:0] q_reg, q_next;
    logic signed [63:0] a_reg, a_next;
    logic [63:0]        ma_reg, ma_next;
    logic signed [32:0] acc_reg, acc_next;
    logic signed [63:0] nv_reg, nv_next;
    logic signed [63:0] np_reg, np_next;

    logic [15:0]        n_eff;
    logic signed [63:0] pos_w, vel_w, tgt_w, d_s, vmax_s;
    logic [63:0]        vel_mag, acc_mag;
    logic [63:0]        step;
    logic [ROOT_W-1:0]  root_d;
    logic [31:0]        m_q;

    mul_req_t           mul_req;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_prod;
    dsq_req_t           dsq_req;
    logic               dsq_done;
    logic [DSQ_RES_W-1:0] dsq_res;

    tdf_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tdf_divsqrt u_dsq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dsq_req),
        .done  (dsq_done),
        .res   (dsq_res)
    );

    // Widen the state and operands
    assign n_eff   = (n_reg < N_ONE) ? N_ONE : n_reg;
    assign pos_w   = {{(64-DATA_WIDTH){pos_reg[DATA_WIDTH-1]}}, pos_reg};
    assign vel_w   = {{(64-DATA_WIDTH){vel_reg[DATA_WIDTH-1]}}, vel_reg};
    assign tgt_w   = {{32{tgt_reg[31]}}, tgt_reg};
    assign d_s     = {32'b0, d_reg};
    assign vmax_s  = {33'b0, vmax_reg};
    assign vel_mag = vel_w[63] ? -vel_w : vel_w;
    assign acc_mag = {31'b0, (acc_reg[32] ? -acc_reg : acc_reg)};
    assign step    = mul_prod[MUL_P_W-1:32];
    assign root_d  = dsq_res[ROOT_W-1:0] - {{(ROOT_W-32){1'b0}}, d_reg};
    assign m_q     = dsq_res[31:0];

    // Drive the shared units from the sequencer state
    always_comb
    begin
        mul_req       = '0;
        dsq_req       = '0;
        dsq_req.mode  = DSQ_DIV;
        case (state_reg)
            ST_H0:
            begin
                mul_req.start = go_reg;
                mul_req.a     = {48'b0, n_eff};
                mul_req.b     = h_reg;
            end
            ST_D:
            begin
                mul_req.start = go_reg;
                mul_req.a     = {32'b0, r_reg};
                mul_req.b     = h_reg;
            end
            ST_D0:
            begin
                mul_req.start = go_reg;
                mul_req.a     = {24'b0, h0_reg};
                mul_req.b     = d_reg;
            end
            ST_VH:
            begin
                mul_req.start = go_reg;
                mul_req.a     = vel_mag;
                mul_req.b     = h_reg;
            end
            ST_ARGA:
            begin
                mul_req.start = go_reg;
                mul_req.a     = ay_reg;
                mul_req.b     = r_reg;
            end
            ST_ARGB:
            begin
                mul_req.start = go_reg;
                mul_req.a     = {32'b0, d_reg};
                mul_req.b     = d_reg;
            end
            ST_ACCM:
            begin
                mul_req.start = go_reg;
                mul_req.a     = ma_reg;
                mul_req.b     = r_reg;
            end
            ST_AH:
            begin
                mul_req.start = go_reg;
                mul_req.a     = acc_mag;
                mul_req.b     = h_reg;
            end
            ST_PVH:
            begin
                mul_req.start = go_reg;
                mul_req.a     = vel_mag;
                mul_req.b     = h_reg;
            end
            ST_LDIV:
            begin
                dsq_req.start = go_reg;
                dsq_req.arg   = {ay_reg[39:0], 32'b0, 28'b0};
                dsq_req.den   = h_reg;
            end
            ST_SQRT:
            begin
                dsq_req.start = go_reg;
                dsq_req.mode  = DSQ_SQRT;
                dsq_req.arg   = arg_reg;
            end
            ST_ACCD:
            begin
                dsq_req.start = go_reg;
                dsq_req.arg   = {8'b0, ma_reg, 28'b0};
                dsq_req.den   = d_reg;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        r_next         = r_reg;
        h_next         = h_reg;
        n_next         = n_reg;
        vmax_next      = vmax_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        tgt_next       = tgt_reg;
        err_next       = err_reg;
        h0_next        = h0_reg;
        d_next         = d_reg;
        d0_next        = d0_reg;
        y_next         = y_reg;
        ay_next        = ay_reg;
        arg_next       = arg_reg;
        q_next         = q_reg;
        a_next         = a_reg;
        ma_next        = ma_reg;
        acc_next       = acc_reg;
        nv_next        = nv_reg;
        np_next        = np_reg;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACCEL_LIMIT: r_next    = cfg_data;
                CFG_PERIOD_H:    h_next    = cfg_data;
                CFG_FILTER_N:    n_next    = cfg_data[15:0];
                CFG_MAX_VEL:     vmax_next = cfg_data[30:0];
                default:         r_next    = r_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tgt_next = value_in;
                    if (req_type)
                    begin
                        pos_next   = sat_data({{32{value_in[31]}}, value_in});
                        vel_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_H0;
                    end
                end
            end
            ST_H0:
            begin
                err_next = pos_w - tgt_w;
                if (mul_done)
                begin
                    h0_next    = mul_prod[47:8];
                    state_next = ST_D;
                end
            end
            ST_D:
            begin
                if (mul_done)
                begin
                    d_next     = mul_prod[63:32];
                    state_next = ST_D0;
                end
            end
            ST_D0:
            begin
                if (mul_done)
                begin
                    d0_next    = mul_prod[71:32];
                    state_next = ST_VH;
                end
            end
            ST_VH:
            begin
                if (mul_done)
                begin
                    y_next     = vel_w[63] ? err_reg - $signed(step) : err_reg + $signed(step);
                    state_next = ST_YABS;
                end
            end
            ST_YABS:
            begin
                ay_next    = y_reg[63] ? -y_reg : y_reg;
                state_next = ST_ARGA;
            end
            ST_ARGA:
            begin
                if (mul_done)
                begin
                    arg_next   = {1'b0, mul_prod, 3'b0};
                    state_next = ST_ARGB;
                end
            end
            ST_ARGB:
            begin
                if (mul_done)
                begin
                    arg_next   = arg_reg + {36'b0, mul_prod[63:0]};
                    state_next = ST_BR;
                end
            end
            ST_BR:
            begin
                // Linear zone when |y| is within d0, else the root zone
                if (ay_reg <= {24'b0, d0_reg})
                begin
                    if (h_reg == '0)
                    begin
                        q_next     = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_LDIV;
                    end
                end
                else
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_LDIV:
            begin
                if (dsq_done)
                begin
                    q_next     = (dsq_res > {8'b0, WIDE_LIM}) ? WIDE_LIM : dsq_res[63:0];
                    state_next = ST_SUM;
                end
            end
            ST_SQRT:
            begin
                if (dsq_done)
                begin
                    q_next     = {15'b0, root_d[ROOT_W-1:1]};
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                a_next     = y_reg[63] ? vel_w - q_reg : vel_w + q_reg;
                state_next = ST_ACCA;
            end
            ST_ACCA:
            begin
                if (a_reg > $signed(WIDE_LIM))
                begin
                    a_next = WIDE_LIM;
                end
                else if (a_reg < -$signed(WIDE_LIM))
                begin
                    a_next = -$signed(WIDE_LIM);
                end
                state_next = ST_ACCB;
            end
            ST_ACCB:
            begin
                ma_next = a_reg[63] ? -a_reg : a_reg;
                if (a_reg <= d_s && a_reg >= -d_s)
                begin
                    if (d_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_AH;
                    end
                    else
                    begin
                        state_next = ST_ACCM;
                    end
                end
                else
                begin
                    acc_next   = (a_reg > 0) ? -$signed({1'b0, r_reg}) : $signed({1'b0, r_reg});
                    state_next = ST_AH;
                end
            end
            ST_ACCM:
            begin
                if (mul_done)
                begin
                    ma_next    = mul_prod[63:0];
                    state_next = ST_ACCD;
                end
            end
            ST_ACCD:
            begin
                if (dsq_done)
                begin
                    acc_next   = (a_reg > 0) ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});
                    state_next = ST_AH;
                end
            end
            ST_AH:
            begin
                if (mul_done)
                begin
                    nv_next    = acc_reg[32] ? vel_w - $signed(step) : vel_w + $signed(step);
                    state_next = ST_VCLP;
                end
            end
            ST_VCLP:
            begin
                if (vmax_reg != '0)
                begin
                    if (nv_reg > vmax_s)
                    begin
                        nv_next = vmax_s;
                    end
                    else if (nv_reg < -vmax_s)
                    begin
                        nv_next = -vmax_s;
                    end
                end
                state_next = ST_VSAT;
            end
            ST_VSAT:
            begin
                vel_next   = sat_data(nv_reg);
                state_next = ST_PVH;
            end
            ST_PVH:
            begin
                if (mul_done)
                begin
                    np_next    = vel_w[63] ? pos_w - $signed(step) : pos_w + $signed(step);
                    state_next = ST_PSAT;
                end
            end
            ST_PSAT:
            begin
                pos_next   = sat_data(np_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pos_w[31:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        go_next = (state_next != state_reg);
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            r_reg         <= 32'd6553600;
            h_reg         <= 32'd4294967;
            n_reg         <= N_ONE;
            vmax_reg      <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            r_reg         <= r_next;
            h_reg         <= h_next;
            n_reg         <= n_next;
            vmax_reg      <= vmax_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        tgt_reg      <= tgt_next;
        err_reg      <= err_next;
        h0_reg       <= h0_next;
        d_reg        <= d_next;
        d0_reg       <= d0_next;
        y_reg        <= y_next;
        ay_reg       <= ay_next;
        arg_reg      <= arg_next;
        q_reg        <= q_next;
        a_reg        <= a_next;
        ma_reg       <= ma_next;
        acc_reg      <= acc_next;
        nv_reg       <= nv_next;
        np_reg       <= np_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign position_out = out_data_reg;
    assign cfg_ready    = 1'b1;

endmodule

@@ rtl/tdf_mul.sv @@
module tdf_mul
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tdf_pkg::mul_req_t          req,
    output logic                       done,
    output logic [tdf_pkg::MUL_P_W-1:0] prod
);
    import tdf_pkg::*;

    typedef enum logic [3:0]
    {
        M_IDLE = 4'b0001,
        M_LO   = 4'b0010,
        M_HI   = 4'b0100,
        M_SUM  = 4'b1000
    } mul_state_t;

    mul_state_t           state_reg, state_next;
    logic                 done_reg, done_next;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [63:0]          pp_reg;
    logic [63:0]          lo_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [31:0]          part;
    logic [63:0]          pp_next;

    // Pick the half of the wide operand for this pass
    assign part    = (state_reg == M_LO) ? a_reg[31:0] : a_reg[63:32];
    assign pp_next = part * b_reg;

    // Sequence the two partial products and the final sum
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    state_next = M_LO;
                end
            end
            M_LO:  state_next = M_HI;
            M_HI:  state_next = M_SUM;
            M_SUM:
            begin
                state_next = M_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Operand capture and partial product datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (state_reg == M_LO)
        begin
            pp_reg <= pp_next;
        end
        if (state_reg == M_HI)
        begin
            lo_reg <= pp_reg;
            pp_reg <= pp_next;
        end
        if (state_reg == M_SUM)
        begin
            prod_reg <= {pp_reg, 32'b0} + {32'b0, lo_reg};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ rtl/tdf_divsqrt.sv @@
module tdf_divsqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdf_pkg::dsq_req_t             req,
    output logic                          done,
    output logic [tdf_pkg::DSQ_RES_W-1:0] res
);
    import tdf_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DSQ_CNT_W-1:0]  cnt_reg;
    dsq_mode_t             mode_reg;
    logic [DSQ_ARG_W-1:0]  src_reg;
    logic [DSQ_REM_W-1:0]  rem_reg;
    logic [DSQ_RES_W-1:0]  res_reg;
    logic [DSQ_DEN_W-1:0]  den_reg;

    logic [DSQ_REM_W-1:0]  rem_sh;
    logic [DSQ_REM_W-1:0]  sub;
    logic [DSQ_REM_W:0]    diff;
    logic                  take;

    // Bring down one dividend bit or two radicand bits, then trial subtract
    always_comb
    begin
        if (mode_reg == DSQ_DIV)
        begin
            rem_sh = {rem_reg[DSQ_REM_W-2:0], src_reg[DSQ_ARG_W-1]};
            sub    = {{(DSQ_REM_W-DSQ_DEN_W){1'b0}}, den_reg};
        end
        else
        begin
            rem_sh = {rem_reg[DSQ_REM_W-3:0], src_reg[DSQ_ARG_W-1 -: 2]};
            sub    = {2'b0, res_reg[ROOT_W-1:0], 2'b01};
        end
        diff = {1'b0, rem_sh} - {1'b0, sub};
        take = !diff[DSQ_REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.mode == DSQ_DIV) ? DSQ_CNT_W'(DIV_STEPS)
                                                  : DSQ_CNT_W'(SQRT_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DSQ_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the operand through and build the result one bit a cycle
    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            mode_reg <= req.mode;
            src_reg  <= req.arg;
            den_reg  <= req.den;
            rem_reg  <= '0;
            res_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DSQ_REM_W-1:0] : rem_sh;
            res_reg <= {res_reg[DSQ_RES_W-2:0], take};
            src_reg <= (mode_reg == DSQ_DIV) ? {src_reg[DSQ_ARG_W-2:0], 1'b0}
                                             : {src_reg[DSQ_ARG_W-3:0], 2'b0};
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/tdf_checker.sv @@
module tdf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        req_type,
    input logic [31:0] value_in,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] position_out
);

    // A stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(value_in) && $stable(req_type)))
        else $error("input word changed while stalled");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(position_out)))
        else $error("output word changed while stalled");

    // One word in flight: busy right after accepting
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while busy");

    // A load word accepted with the output register empty reaches it by way of ST_OUT
    a_load_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type && !out_valid) |-> ##2 out_valid)
        else $error("load word result missing");

endmodule

bind tracking_differentiator_fhan_core tdf_checker u_tdf_checker (.*);
